/* design/i2cseq_pkg.sv */
`timescale 1ns / 1ps

package i2cseq_pkg;

  localparam int BUFFER_DEPTH_DEF = 16;

  // item kinds
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_START  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // transfer modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRRD  = 2'd2;

  // control actions toward the bus controller
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SI      = 3'd1,
    ACT_SI_ACK  = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_RESTART = 3'd4
  } act_e;

  // bus controller status codes
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
  localparam logic [7:0] ST_SLAW_NACK   = 8'h20;
  localparam logic [7:0] ST_DATAW_ACK   = 8'h28;
  localparam logic [7:0] ST_DATAW_NACK  = 8'h30;
  localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
  localparam logic [7:0] ST_SLAR_NACK   = 8'h48;
  localparam logic [7:0] ST_DATAR_ACK   = 8'h50;
  localparam logic [7:0] ST_DATAR_NACK  = 8'h58;

  // one result; send_from_buf selects the buffer read data for send_byte
  typedef struct packed {
    logic       start_refused;
    act_e       action;
    logic       send_valid;
    logic       send_from_buf;
    logic [7:0] send_byte;
    logic       received_valid;
    logic [3:0] received_index;
    logic [7:0] received_byte;
    logic       busy;
    logic       error;
  } res_t;

endpackage

/* design/i2cseq_wbuf.sv */
`timescale 1ns / 1ps

module i2cseq_wbuf #(
  parameter int BUFFER_DEPTH = i2cseq_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rd_data_q;

  // a load also reads, but its read data is never used
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/i2cseq_ctl.sv */
`timescale 1ns / 1ps

module i2cseq_ctl #(
  parameter int BUFFER_DEPTH = i2cseq_pkg::BUFFER_DEPTH_DEF,
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              accept_i,
  input  logic [1:0]        kind_i,
  input  logic [1:0]        mode_i,
  input  logic [4:0]        write_length_i,
  input  logic [4:0]        read_length_i,
  input  logic [3:0]        load_index_i,
  input  logic [7:0]        byte_value_i,
  input  logic [7:0]        status_code_i,
  output i2cseq_pkg::res_t  res_o,
  output logic              wr_en_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic [7:0]        wr_data_o,
  output logic [AW-1:0]     rd_addr_o
);

  localparam logic [4:0] PosLast = '1;

  logic [6:0]    slave_addr_q;
  logic          busy_q, busy_d;
  logic          failed_q, failed_d;
  logic [1:0]    mode_q, mode_d;
  logic [4:0]    pos_q, pos_d;
  logic [4:0]    wleft_q, wleft_d;
  logic [4:0]    rleft_q, rleft_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] ptr_inc;
  logic [4:0]    rleft_dec;
  logic [7:0]    sla_w, sla_r;
  logic          m_wr, m_rd, m_wrrd;
  i2cseq_pkg::res_t res;

  assign sla_w  = {slave_addr_q, 1'b0};
  assign sla_r  = {slave_addr_q, 1'b1};
  assign m_wr   = (mode_q == i2cseq_pkg::MODE_WRITE);
  assign m_rd   = (mode_q == i2cseq_pkg::MODE_READ);
  assign m_wrrd = (mode_q == i2cseq_pkg::MODE_WRRD);

  // ptr_q tracks pos_q modulo the buffer depth
  always_comb begin
    if (pos_q == PosLast) begin
      ptr_inc = '0;
    end else if (ptr_q == AW'(BUFFER_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = ptr_q + AW'(1);
    end
  end

  assign rleft_dec = (rleft_q != 5'd0) ? rleft_q - 5'd1 : 5'd0;

  always_comb begin
    res      = '0;
    busy_d   = busy_q;
    failed_d = failed_q;
    mode_d   = mode_q;
    pos_d    = pos_q;
    wleft_d  = wleft_q;
    rleft_d  = rleft_q;
    ptr_d    = ptr_q;
    wr_en_o  = 1'b0;
    if (accept_i) begin
      case (kind_i)
        i2cseq_pkg::KIND_LOAD: begin
          if (int'(load_index_i) < BUFFER_DEPTH) begin
            wr_en_o = 1'b1;
          end
        end
        i2cseq_pkg::KIND_START: begin
          if (busy_q) begin
            res.start_refused = 1'b1;
          end else if (mode_i == i2cseq_pkg::MODE_WRITE || mode_i == i2cseq_pkg::MODE_READ ||
                       mode_i == i2cseq_pkg::MODE_WRRD) begin
            busy_d   = 1'b1;
            failed_d = 1'b0;
            mode_d   = mode_i;
            pos_d    = '0;
            ptr_d    = '0;
            wleft_d  = (mode_i == i2cseq_pkg::MODE_READ) ? 5'd0 : write_length_i;
            rleft_d  = (mode_i == i2cseq_pkg::MODE_WRITE) ? 5'd0 : read_length_i;
          end
        end
        i2cseq_pkg::KIND_STATUS: begin
          if (busy_q) begin
            if (status_code_i == i2cseq_pkg::ST_START) begin
              res.send_valid = 1'b1;
              res.send_byte  = m_rd ? sla_r : sla_w;
              res.action     = i2cseq_pkg::ACT_SI;
            end else if (status_code_i == i2cseq_pkg::ST_RESTART && m_wrrd) begin
              res.send_valid = 1'b1;
              res.send_byte  = sla_r;
              res.action     = i2cseq_pkg::ACT_SI;
            end else if ((status_code_i == i2cseq_pkg::ST_SLAW_ACK ||
                          status_code_i == i2cseq_pkg::ST_DATAW_ACK) && !m_rd) begin
              if (wleft_q != 5'd0) begin
                res.send_valid    = 1'b1;
                res.send_from_buf = 1'b1;
                res.action        = i2cseq_pkg::ACT_SI;
                wleft_d           = wleft_q - 5'd1;
                pos_d             = pos_q + 5'd1;
                ptr_d             = ptr_inc;
              end else if (m_wr) begin
                res.action = i2cseq_pkg::ACT_STOP;
                busy_d     = 1'b0;
                failed_d   = 1'b0;
              end else begin
                res.action = i2cseq_pkg::ACT_RESTART;
                pos_d      = '0;
                ptr_d      = '0;
              end
            end else if ((status_code_i == i2cseq_pkg::ST_SLAW_NACK ||
                          status_code_i == i2cseq_pkg::ST_DATAW_NACK) && !m_rd) begin
              res.action = i2cseq_pkg::ACT_STOP;
              busy_d     = 1'b0;
              failed_d   = 1'b1;
            end else if (status_code_i == i2cseq_pkg::ST_SLAR_ACK && !m_wr) begin
              res.action = i2cseq_pkg::ACT_SI_ACK;
            end else if (status_code_i == i2cseq_pkg::ST_SLAR_NACK && !m_wr) begin
              res.action = i2cseq_pkg::ACT_STOP;
              busy_d     = 1'b0;
              failed_d   = 1'b1;
            end else if (status_code_i == i2cseq_pkg::ST_DATAR_ACK && !m_wr) begin
              res.received_valid = 1'b1;
              res.received_index = pos_q[3:0];
              res.received_byte  = byte_value_i;
              rleft_d            = rleft_dec;
              pos_d              = pos_q + 5'd1;
              ptr_d              = ptr_inc;
              res.action         = (rleft_dec > 5'd1) ? i2cseq_pkg::ACT_SI_ACK
                                                      : i2cseq_pkg::ACT_SI;
            end else if (status_code_i == i2cseq_pkg::ST_DATAR_NACK && !m_wr) begin
              res.received_valid = 1'b1;
              res.received_index = pos_q[3:0];
              res.received_byte  = byte_value_i;
              res.action         = i2cseq_pkg::ACT_STOP;
              busy_d             = 1'b0;
            end else begin
              // unknown status or one that does not fit the mode
              res.action = i2cseq_pkg::ACT_STOP;
              busy_d     = 1'b0;
              failed_d   = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.busy  = busy_d;
    res.error = failed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= '0;
      busy_q       <= 1'b0;
      failed_q     <= 1'b0;
      mode_q       <= '0;
      pos_q        <= '0;
      wleft_q      <= '0;
      rleft_q      <= '0;
      ptr_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        slave_addr_q <= cfg_wdata_i;
      end
      busy_q   <= busy_d;
      failed_q <= failed_d;
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      wleft_q  <= wleft_d;
      rleft_q  <= rleft_d;
      ptr_q    <= ptr_d;
    end
  end

  assign res_o     = res;
  assign wr_addr_o = AW'(load_index_i);
  assign wr_data_o = byte_value_i;
  assign rd_addr_o = ptr_q;

endmodule

/* design/i2cseq_out.sv */
`timescale 1ns / 1ps

module i2cseq_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  i2cseq_pkg::res_t res_i,
  input  logic [7:0]       buf_data_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output i2cseq_pkg::res_t out_o
);

  logic             s1_valid_q, s1_valid_d;
  i2cseq_pkg::res_t s1_q;
  logic             out_valid_q, out_valid_d;
  i2cseq_pkg::res_t out_q;
  i2cseq_pkg::res_t s1_res;
  logic             s1_move;

  // buffer read data is registered together with the item in s1_q; merge it here
  always_comb begin
    s1_res = s1_q;
    if (s1_q.send_from_buf) begin
      s1_res.send_byte = buf_data_i;
    end
    s1_res.send_from_buf = 1'b0;
  end

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= res_i;
    end
    if (s1_move) begin
      out_q <= s1_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* design/i2c_master_transfer_sequencer.sv */
`timescale 1ns / 1ps

// I2C master transfer sequencer.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer: a
// write buffer load, a transaction start, or a bus status event from the I2C
// controller. Every accepted item yields exactly one result on the output
// channel (out_valid_o / out_stall_i): the control action, an address or
// data byte to send, a received byte with its index, and the busy and error
// flags after the item. The user must write the slave address via cfg_we_i /
// cfg_wdata_i while the block is idle; the block does not enforce this.
// Throughput is one item per cycle while the receiver does not stall. The
// middle stage reads the write buffer memory (synchronous read at the
// current byte position), then the output stage registers the merged
// result.
// When the receiver stalls, the result holds in the output register and one
// more item is taken into the middle stage; after that in_stall_o rises.
// Reset clears the flags, counts, position and slave address; buffer
// contents are undefined until loaded.
module i2c_master_transfer_sequencer #(
  parameter int BUFFER_DEPTH = i2cseq_pkg::BUFFER_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [1:0] mode_i,
  input  logic [4:0] write_length_i,
  input  logic [4:0] read_length_i,
  input  logic [3:0] load_index_i,
  input  logic [7:0] byte_value_i,
  input  logic [7:0] status_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       start_refused_o,
  output logic [2:0] control_action_o,
  output logic       send_valid_o,
  output logic [7:0] send_byte_o,
  output logic       received_valid_o,
  output logic [3:0] received_index_o,
  output logic [7:0] received_byte_o,
  output logic       busy_flag_o,
  output logic       error_flag_o
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic             accept;
  i2cseq_pkg::res_t res;
  i2cseq_pkg::res_t out;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;

  assign accept = in_valid_i && !in_stall_o;

  i2cseq_ctl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .mode_i        (mode_i),
    .write_length_i(write_length_i),
    .read_length_i (read_length_i),
    .load_index_i  (load_index_i),
    .byte_value_i  (byte_value_i),
    .status_code_i (status_code_i),
    .res_o         (res),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_addr_o     (rd_addr)
  );

  i2cseq_wbuf #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_wbuf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (accept),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  i2cseq_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .res_i      (res),
    .buf_data_i (rd_data),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out)
  );

  assign start_refused_o  = out.start_refused;
  assign control_action_o = out.action;
  assign send_valid_o     = out.send_valid;
  assign send_byte_o      = out.send_byte;
  assign received_valid_o = out.received_valid;
  assign received_index_o = out.received_index;
  assign received_byte_o  = out.received_byte;
  assign busy_flag_o      = out.busy;
  assign error_flag_o     = out.error;

endmodule

/* design/i2cseq_checker.sv */
`timescale 1ns / 1ps

module i2cseq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       start_refused_o,
  input logic [2:0] control_action_o,
  input logic       send_valid_o,
  input logic [7:0] send_byte_o,
  input logic       received_valid_o,
  input logic       busy_flag_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(control_action_o) &&
    $stable(send_byte_o) && $stable(busy_flag_o))
    else $error("stalled result changed");

  // a refused start leaves the transfer running and drives nothing
  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_refused_o |->
    busy_flag_o && control_action_o == i2cseq_pkg::ACT_NONE && !send_valid_o &&
    !received_valid_o)
    else $error("refused start with side effects");

  // STOP always ends the transfer
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && control_action_o == i2cseq_pkg::ACT_STOP |-> !busy_flag_o)
    else $error("STOP while still busy");

  // ACK and repeated START keep the transfer going
  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (control_action_o == i2cseq_pkg::ACT_SI_ACK ||
    control_action_o == i2cseq_pkg::ACT_RESTART) |-> busy_flag_o)
    else $error("continuing action without busy");

  // a received byte comes with an SI clear or a STOP and never with a send
  a_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && received_valid_o |->
    !send_valid_o && (control_action_o == i2cseq_pkg::ACT_SI ||
    control_action_o == i2cseq_pkg::ACT_SI_ACK || control_action_o == i2cseq_pkg::ACT_STOP))
    else $error("bad action with received byte");

endmodule

bind i2c_master_transfer_sequencer i2cseq_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .start_refused_o (start_refused_o),
  .control_action_o(control_action_o),
  .send_valid_o    (send_valid_o),
  .send_byte_o     (send_byte_o),
  .received_valid_o(received_valid_o),
  .busy_flag_o     (busy_flag_o)
);
